@@ hw/rtl/hbcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hbcd_pkg
// Shared types, character codes and helpers for the HTTP body deframer.
// ----------------------------------------------------------------------------
package hbcd_pkg;

    // default width of the length and chunk-size counters
    localparam int unsigned LENGTH_BITS_DEF = 32;

    // line-end characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // item kinds on the input channel
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // body framing mode
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_CHUNKED = 2'd1,
        MODE_COUNTED = 2'd2,
        MODE_CLOSE   = 2'd3
    } t_body_mode;

    // position inside the chunked coding
    typedef enum logic [2:0] {
        PH_SIZE  = 3'd0,
        PH_DATA  = 3'd1,
        PH_SKIP1 = 3'd2,
        PH_SKIP2 = 3'd3,
        PH_TAIL  = 3'd4
    } t_chunk_phase;

    // one input request
    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic        chunked;
        logic        persistent;
        logic [31:0] body_length;
    } t_in_item;

    // one result
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       message_done;
        logic       leftover;
        logic       size_overflow;
    } t_result;

    // hex digit decode: bit 4 flags a digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/hbcd_core.sv @@
// ----------------------------------------------------------------------------
// hbcd_core
// Framing state and single-pass step logic: one request per enabled cycle.
// ----------------------------------------------------------------------------
module hbcd_core #(
    parameter int unsigned LENGTH_BITS = hbcd_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hbcd_pkg::t_in_item i_item,
    output hbcd_pkg::t_result  o_result
);

    localparam int unsigned W = LENGTH_BITS;

    // framing state
    hbcd_pkg::t_body_mode   r_mode,   n_mode;
    hbcd_pkg::t_chunk_phase r_phase,  n_phase;
    logic [W-1:0]           r_chunk,  n_chunk;
    logic [W-1:0]           r_body,   n_body;
    logic                   r_digits, n_digits;
    logic                   r_cr,     n_cr;

    // shared decode
    logic [W-1:0] w_len;
    logic [W-1:0] w_body_dec;
    logic [W-1:0] w_chunk_dec;
    logic [4:0]   w_hex;
    logic         w_line_end;
    logic         w_is_cr;
    logic         w_take_digit;
    logic         w_size_sat;

    assign w_len        = W'(i_item.body_length);
    assign w_body_dec   = r_body - W'(1);
    assign w_chunk_dec  = r_chunk - W'(1);
    assign w_hex        = hbcd_pkg::hex_digit(i_item.data_byte);
    assign w_is_cr      = (i_item.data_byte == hbcd_pkg::CH_CR);
    assign w_line_end   = r_cr && (i_item.data_byte == hbcd_pkg::CH_LF);
    assign w_take_digit = !r_digits && w_hex[4];
    assign w_size_sat   = (r_chunk[W-1 -: 4] != 4'd0);

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_chunk  = r_chunk;
        n_body   = r_body;
        n_digits = r_digits;
        n_cr     = r_cr;
        if (i_en) begin
            if (i_item.action == hbcd_pkg::ACT_START) begin
                n_phase  = hbcd_pkg::PH_SIZE;
                n_chunk  = '0;
                n_digits = 1'b0;
                n_cr     = 1'b0;
                if (i_item.chunked) begin
                    n_mode = hbcd_pkg::MODE_CHUNKED;
                    n_body = '0;
                end else if (i_item.persistent) begin
                    n_body = w_len;
                    n_mode = (w_len == '0) ? hbcd_pkg::MODE_IDLE : hbcd_pkg::MODE_COUNTED;
                end else begin
                    n_mode = hbcd_pkg::MODE_CLOSE;
                    n_body = w_len;
                end
            end else begin
                case (r_mode)
                    hbcd_pkg::MODE_IDLE: begin
                    end
                    hbcd_pkg::MODE_COUNTED: begin
                        n_body = w_body_dec;
                        if (w_body_dec == '0) begin
                            n_mode = hbcd_pkg::MODE_IDLE;
                        end
                    end
                    hbcd_pkg::MODE_CLOSE: begin
                        n_body = w_body_dec;
                    end
                    hbcd_pkg::MODE_CHUNKED: begin
                        case (r_phase)
                            hbcd_pkg::PH_SIZE: begin
                                if (w_take_digit) begin
                                    if (w_size_sat) begin
                                        n_chunk = '1;
                                    end else begin
                                        n_chunk = {r_chunk[W-5:0], w_hex[3:0]};
                                    end
                                end else begin
                                    n_digits = 1'b1;
                                end
                                if (w_line_end) begin
                                    n_phase  = (n_chunk == '0) ? hbcd_pkg::PH_TAIL
                                                               : hbcd_pkg::PH_DATA;
                                    n_digits = 1'b0;
                                    n_cr     = 1'b0;
                                end else begin
                                    n_cr = w_is_cr;
                                end
                            end
                            hbcd_pkg::PH_DATA: begin
                                n_chunk = w_chunk_dec;
                                if (w_chunk_dec == '0) begin
                                    n_phase = hbcd_pkg::PH_SKIP1;
                                end
                            end
                            hbcd_pkg::PH_SKIP1: begin
                                n_phase = hbcd_pkg::PH_SKIP2;
                            end
                            hbcd_pkg::PH_SKIP2: begin
                                n_phase  = hbcd_pkg::PH_SIZE;
                                n_chunk  = '0;
                                n_digits = 1'b0;
                                n_cr     = 1'b0;
                            end
                            default: begin
                                // waiting for the CR LF after the last chunk
                                if (w_line_end) begin
                                    n_mode   = hbcd_pkg::MODE_IDLE;
                                    n_body   = '0;
                                    n_phase  = hbcd_pkg::PH_SIZE;
                                    n_chunk  = '0;
                                    n_digits = 1'b0;
                                    n_cr     = 1'b0;
                                end else begin
                                    n_cr = w_is_cr;
                                end
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result for the current request
    always_comb begin
        o_result = '0;
        if (i_item.action == hbcd_pkg::ACT_START) begin
            if (!i_item.chunked) begin
                o_result.message_done = (w_len == '0);
            end
        end else begin
            case (r_mode)
                hbcd_pkg::MODE_IDLE: begin
                    o_result.leftover     = 1'b1;
                    o_result.payload_byte = i_item.data_byte;
                end
                hbcd_pkg::MODE_COUNTED,
                hbcd_pkg::MODE_CLOSE: begin
                    o_result.payload_valid = 1'b1;
                    o_result.payload_byte  = i_item.data_byte;
                    o_result.message_done  = (w_body_dec == '0);
                end
                hbcd_pkg::MODE_CHUNKED: begin
                    case (r_phase)
                        hbcd_pkg::PH_SIZE: begin
                            o_result.size_overflow = w_take_digit && w_size_sat;
                        end
                        hbcd_pkg::PH_DATA: begin
                            o_result.payload_valid = 1'b1;
                            o_result.payload_byte  = i_item.data_byte;
                        end
                        hbcd_pkg::PH_SKIP1,
                        hbcd_pkg::PH_SKIP2: begin
                        end
                        default: begin
                            o_result.message_done = w_line_end;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= hbcd_pkg::MODE_IDLE;
            r_phase  <= hbcd_pkg::PH_SIZE;
            r_chunk  <= '0;
            r_body   <= '0;
            r_digits <= 1'b0;
            r_cr     <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_chunk  <= n_chunk;
            r_body   <= n_body;
            r_digits <= n_digits;
            r_cr     <= n_cr;
        end
    end

endmodule

@@ hw/rtl/http_body_chunked_deframer.sv @@
// ----------------------------------------------------------------------------
// http_body_chunked_deframer
// Byte-wide HTTP/1.1 message body deframer (chunked, counted, close-delimited).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one request per accept: a start
//   request (i_action = 0) loads the body mode from i_chunked, i_persistent and
//   i_body_length; a byte request (i_action = 1) carries i_data_byte.
//   Output channel (o_valid/i_ready) returns exactly one result per request:
//   body data flag and byte, message completion, leftover marking for bytes
//   outside a body, and chunk-size overflow.
//   A request waits in the request register until the result register frees.
//   Throughput: one request per cycle while i_ready stays high; the request
//   register and the result register form a two-entry pipeline, and the step
//   logic between them is a single pass through the framing state.
//   A stalled receiver holds the result register; the request register still
//   takes one more request, after which o_ready drops until the result drains.
//   Reset (synchronous, active low) empties both registers and returns the
//   framing state to idle header mode.
// ----------------------------------------------------------------------------
module http_body_chunked_deframer #(
    parameter int unsigned LENGTH_BITS = hbcd_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunked,
    input  logic        i_persistent,
    input  logic [31:0] i_body_length,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_message_done,
    output logic        o_leftover,
    output logic        o_size_overflow
);

    logic               r_in_valid;
    hbcd_pkg::t_in_item r_in;
    logic               r_out_valid;
    hbcd_pkg::t_result  r_out;
    hbcd_pkg::t_result  w_result;
    logic               w_adv;

    // request register moves into the result register when that one is free
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.action      <= i_action;
            r_in.data_byte   <= i_data_byte;
            r_in.chunked     <= i_chunked;
            r_in.persistent  <= i_persistent;
            r_in.body_length <= i_body_length;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // framing step
    hbcd_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_in),
        .o_result (w_result)
    );

    assign o_valid         = r_out_valid;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_message_done  = r_out.message_done;
    assign o_leftover      = r_out.leftover;
    assign o_size_overflow = r_out.size_overflow;

    // an empty result register never blocks new requests
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("request channel stalled with empty result register");

    // body data and leftover are exclusive
    a_data_xor_left : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_payload_valid && o_leftover))
        else $error("byte flagged as body data and leftover");

    // overflow only on a size-line digit
    a_ovf_alone : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_size_overflow) |-> (!o_payload_valid && !o_message_done && !o_leftover))
        else $error("size overflow with other result flags");

    // a result is only produced from a held request
    a_out_from_in : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request");

endmodule
